// File: design/gsir_pkg.sv
package gsir_pkg;

    // Sizing
    localparam int UNIFORM_REGS = 96;
    localparam int MAX_ATTRS    = 16;
    localparam int ATTR_W       = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
    localparam int WP_W         = $clog2(UNIFORM_REGS + 1);
    localparam int PADDR_W      = 5;

    // Modes
    localparam logic [1:0] MODE_BYPASS   = 2'd0;
    localparam logic [1:0] MODE_POINT    = 2'd1;
    localparam logic [1:0] MODE_VARIABLE = 2'd2;
    localparam logic [1:0] MODE_FIXED    = 2'd3;

    // Result targets
    localparam logic [1:0] TGT_ASSEMBLER = 2'd0;
    localparam logic [1:0] TGT_GS_INPUT  = 2'd1;
    localparam logic [1:0] TGT_UNIFORM   = 2'd2;
    localparam logic [1:0] TGT_NONE      = 2'd3;

    // Input opcodes
    localparam logic OPC_ATTR  = 1'b0;
    localparam logic OPC_INDEX = 1'b1;

    // Register indexes (word address)
    localparam logic [2:0] REG_MODE           = 3'd0;
    localparam logic [2:0] REG_VS_OUTPUTS     = 3'd1;
    localparam logic [2:0] REG_GS_INPUTS      = 3'd2;
    localparam logic [2:0] REG_MAIN_VERTICES  = 3'd3;
    localparam logic [2:0] REG_FIXED_VERTICES = 3'd4;
    localparam logic [2:0] REG_FIXED_START    = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] vs_outputs;
        logic [4:0] gs_inputs;
        logic [6:0] main_vertices;
        logic [6:0] fixed_vertices;
        logic [6:0] fixed_start;
    } cfg_t;

    typedef struct packed {
        logic              awaiting_count;
        logic [ATTR_W-1:0] attr_position;
        logic [WP_W-1:0]   write_pointer;
        logic [7:0]        main_left;
        logic [7:0]        total_left;
    } run_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  vertex_count;
        logic [23:0] comp_x;
        logic [23:0] comp_y;
        logic [23:0] comp_z;
        logic [23:0] comp_w;
    } item_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [6:0]  dest_index;
        logic [23:0] out_x;
        logic [23:0] out_y;
        logic [23:0] out_z;
        logic [23:0] out_w;
        logic        invoke;
    } result_t;

    localparam run_t RUN_CLEAR = '{awaiting_count: 1'b1, attr_position: '0,
                                   write_pointer: '0, main_left: '0, total_left: '0};

    // Attribute count limited to 1..MAX_ATTRS
    function automatic logic [4:0] clamp_attrs(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > 5'(MAX_ATTRS)) begin
            r = 5'(MAX_ATTRS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Integer count to f24: exponent bias 63, 16-bit mantissa, hidden one dropped
    function automatic logic [23:0] count_to_f24(input logic [7:0] n);
        logic [2:0]  p;
        logic [23:0] sh;
        logic [23:0] r;
        p = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (n[i]) p = 3'(i);
        end
        sh = 24'(n) << (5'd16 - 5'(p));
        if (n == 8'd0) begin
            r = '0;
        end else begin
            r = {1'b0, 7'(p) + 7'd63, sh[15:0]};
        end
        return r;
    endfunction

endpackage

// File: design/gsir_cfg.sv
module gsir_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsir_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gsir_pkg::cfg_t                cfg,
    output logic                          run_clear
);
    import gsir_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       hit;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write decode; a write to a known register also restarts the run
    always_comb begin
        cfg_next = cfg_reg;
        hit      = 1'b1;
        case (reg_idx)
            REG_MODE:           cfg_next.mode           = pwdata[1:0];
            REG_VS_OUTPUTS:     cfg_next.vs_outputs     = pwdata[4:0];
            REG_GS_INPUTS:      cfg_next.gs_inputs      = pwdata[4:0];
            REG_MAIN_VERTICES:  cfg_next.main_vertices  = pwdata[6:0];
            REG_FIXED_VERTICES: cfg_next.fixed_vertices = pwdata[6:0];
            REG_FIXED_START:    cfg_next.fixed_start    = pwdata[6:0];
            default:            hit                     = 1'b0;
        endcase
    end

    assign run_clear = wr_en && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: MODE_BYPASS, vs_outputs: 5'd1, gs_inputs: 5'd1,
                         main_vertices: 7'd1, fixed_vertices: 7'd1, fixed_start: 7'd0};
        end else if (wr_en) begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_MODE:           prdata = 32'(cfg_reg.mode);
            REG_VS_OUTPUTS:     prdata = 32'(cfg_reg.vs_outputs);
            REG_GS_INPUTS:      prdata = 32'(cfg_reg.gs_inputs);
            REG_MAIN_VERTICES:  prdata = 32'(cfg_reg.main_vertices);
            REG_FIXED_VERTICES: prdata = 32'(cfg_reg.fixed_vertices);
            REG_FIXED_START:    prdata = 32'(cfg_reg.fixed_start);
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: design/gsir_route.sv
module gsir_route (
    input  gsir_pkg::item_t   item,
    input  gsir_pkg::run_t    run,
    input  gsir_pkg::cfg_t    cfg,
    output logic              produce,
    output gsir_pkg::result_t result,
    output gsir_pkg::run_t    run_next
);
    import gsir_pkg::*;

    logic [4:0]      vs;
    logic [4:0]      gs;
    logic [6:0]      fv;
    logic            last;
    logic            store;
    logic            inv;
    logic [WP_W-1:0] wp;
    logic [WP_W-1:0] wp_inc;
    logic [23:0]     f;
    logic [7:0]      total_inc;
    logic [7:0]      total_dec;

    // Routing decision and run state update for one word
    always_comb begin
        vs        = clamp_attrs(cfg.vs_outputs);
        gs        = clamp_attrs(cfg.gs_inputs);
        fv        = (cfg.fixed_vertices == 7'd0) ? 7'd1 : cfg.fixed_vertices;
        last      = (5'(run.attr_position) + 5'd1) >= vs;
        f         = count_to_f24(item.vertex_count);
        store     = 1'b0;
        inv       = 1'b0;
        wp        = run.write_pointer;
        wp_inc    = wp + 1'b1;
        total_inc = run.total_left + 8'd1;
        total_dec = run.total_left - 8'd1;
        produce   = 1'b0;
        result    = '0;
        run_next  = run;

        if (item.opcode == OPC_INDEX) begin
            // count item only opens a variable-mode batch
            if (cfg.mode == MODE_VARIABLE && run.awaiting_count) begin
                produce                 = 1'b1;
                result.target           = TGT_UNIFORM;
                result.out_x            = f;
                result.out_y            = f;
                result.out_z            = f;
                result.out_w            = f;
                run_next.attr_position  = '0;
                run_next.write_pointer  = WP_W'(1);
                run_next.main_left      = 8'(cfg.main_vertices);
                run_next.total_left     = item.vertex_count;
                run_next.awaiting_count = (item.vertex_count == 8'd0);
            end
        end else begin
            case (cfg.mode)
                MODE_BYPASS: begin
                    produce                = 1'b1;
                    result.target          = TGT_ASSEMBLER;
                    result.dest_index      = 7'(run.attr_position);
                    result.out_x           = item.comp_x;
                    result.out_y           = item.comp_y;
                    result.out_z           = item.comp_z;
                    result.out_w           = item.comp_w;
                    run_next.attr_position = last ? '0 : run.attr_position + 1'b1;
                end
                MODE_POINT: begin
                    if (wp >= WP_W'(gs)) wp = '0;
                    wp_inc            = wp + 1'b1;
                    produce           = 1'b1;
                    result.target     = TGT_GS_INPUT;
                    result.dest_index = 7'(wp);
                    result.out_x      = item.comp_x;
                    result.out_y      = item.comp_y;
                    result.out_z      = item.comp_z;
                    result.out_w      = item.comp_w;
                    if (wp_inc >= WP_W'(gs)) begin
                        result.invoke          = 1'b1;
                        run_next.write_pointer = '0;
                    end else begin
                        run_next.write_pointer = wp_inc;
                    end
                end
                MODE_FIXED: begin
                    // a run restarts at fixed_start
                    if (run.attr_position == '0 && run.total_left == 8'd0) begin
                        wp = WP_W'(cfg.fixed_start);
                    end
                    wp_inc                 = wp + 1'b1;
                    store                  = wp < WP_W'(UNIFORM_REGS);
                    run_next.write_pointer = store ? wp_inc : wp;
                    if (last) begin
                        run_next.attr_position = '0;
                        if (total_inc >= 8'(fv)) begin
                            inv                 = 1'b1;
                            run_next.total_left = 8'd0;
                        end else begin
                            run_next.total_left = total_inc;
                        end
                    end else begin
                        run_next.attr_position = run.attr_position + 1'b1;
                    end
                end
                default: begin
                    // variable primitive: attributes ignored until a count arrives
                    if (!run.awaiting_count) begin
                        store = (run.main_left != 8'd0 || run.attr_position == '0)
                                && wp < WP_W'(UNIFORM_REGS);
                        run_next.write_pointer = store ? wp_inc : wp;
                        if (last) begin
                            run_next.attr_position = '0;
                            if (run.main_left != 8'd0) begin
                                run_next.main_left = run.main_left - 8'd1;
                            end
                            run_next.total_left = total_dec;
                            if (total_dec == 8'd0) begin
                                inv                     = 1'b1;
                                run_next.awaiting_count = 1'b1;
                            end
                        end else begin
                            run_next.attr_position = run.attr_position + 1'b1;
                        end
                    end
                end
            endcase

            // uniform write, or a bare invoke when the completing write was dropped
            if (cfg.mode == MODE_FIXED || cfg.mode == MODE_VARIABLE) begin
                if (store) begin
                    produce           = 1'b1;
                    result.target     = TGT_UNIFORM;
                    result.dest_index = 7'(wp);
                    result.out_x      = item.comp_x;
                    result.out_y      = item.comp_y;
                    result.out_z      = item.comp_z;
                    result.out_w      = item.comp_w;
                    result.invoke     = inv;
                end else if (inv) begin
                    produce       = 1'b1;
                    result.target = TGT_NONE;
                    result.invoke = 1'b1;
                end
            end
        end
    end

endmodule

// File: design/geometry_shader_input_router.sv
// Geometry shader input router. Takes one vertex attribute or vertex count word
// per cycle on the s_ channel while s_ready is high, and gives at most one routed
// register write per word on the m_ channel (target, index, four f24 components,
// invoke flag). Throughput is one word per cycle while m_ready is high. A word
// accepted on s_ enters the input register; its routed result then enters the
// result register, which drives m_valid. While m_ready is held low, one word
// waits in each register before s_ready drops. Mode and counts are programmed
// over the APB port at byte address 4*index; any register write restarts the
// current batch, so program only while the block is empty.
module geometry_shader_input_router (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsir_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [7:0]                    s_vertex_count,
    input  logic [23:0]                   s_comp_x,
    input  logic [23:0]                   s_comp_y,
    input  logic [23:0]                   s_comp_z,
    input  logic [23:0]                   s_comp_w,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_target,
    output logic [6:0]                    m_dest_index,
    output logic [23:0]                   m_out_x,
    output logic [23:0]                   m_out_y,
    output logic [23:0]                   m_out_z,
    output logic [23:0]                   m_out_w,
    output logic                          m_invoke
);
    import gsir_pkg::*;

    cfg_t    cfg;
    logic    run_clear;
    run_t    run_reg, run_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t out_reg, route_result;
    logic    out_valid_reg, out_valid_next;
    logic    produce;
    logic    advance;

    gsir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .run_clear (run_clear)
    );

    gsir_route u_route (
        .item     (item_reg),
        .run      (run_reg),
        .cfg      (cfg),
        .produce  (produce),
        .result   (route_result),
        .run_next (run_next)
    );

    // Word moves from input register into the result slot when that slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = produce;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= RUN_CLEAR;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            out_valid_reg <= out_valid_next;
            if (run_clear) begin
                run_reg <= RUN_CLEAR;
            end else if (advance) begin
                run_reg <= run_next;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{opcode: s_opcode, vertex_count: s_vertex_count,
                          comp_x: s_comp_x, comp_y: s_comp_y,
                          comp_z: s_comp_z, comp_w: s_comp_w};
        end
        if (advance && produce) out_reg <= route_result;
    end

    assign m_valid      = out_valid_reg;
    assign m_target     = out_reg.target;
    assign m_dest_index = out_reg.dest_index;
    assign m_out_x      = out_reg.out_x;
    assign m_out_y      = out_reg.out_y;
    assign m_out_z      = out_reg.out_z;
    assign m_out_w      = out_reg.out_w;
    assign m_invoke     = out_reg.invoke;

    // A dropped-write result only ever carries the invoke
    a_none_invokes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_target == TGT_NONE |-> m_invoke)
        else $error("target none without invoke");

    // Attribute position stays inside the vertex
    a_attr_in_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        5'(run_reg.attr_position) < clamp_attrs(cfg.vs_outputs))
        else $error("attribute position past vertex end");

    // Register write restarts the batch
    a_clear_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_clear |=> run_reg.awaiting_count && run_reg.write_pointer == '0
                      && run_reg.total_left == 8'd0)
        else $error("run state not cleared by register write");

    // Point mode pointer never exceeds the register file of the shader
    a_point_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.mode == MODE_POINT |-> run_reg.write_pointer <= WP_W'(MAX_ATTRS))
        else $error("point mode pointer out of range");

endmodule
